### rtl/bfdm_pkg.sv
`default_nettype none

package bfdm_pkg;

  localparam int unsigned NumChan    = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CounterWDef = 8;

  // fault word bit positions
  localparam int unsigned FaultOv   = 0;
  localparam int unsigned FaultUv   = 1;
  localparam int unsigned FaultOt   = 2;
  localparam int unsigned FaultOc   = 3;
  localparam int unsigned FaultLink = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegOvLimit   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegUvLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOtLimit   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOcLimit   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDebounce  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWarnTemp  = 3'd5;

  // reset values
  localparam logic        [15:0] OvLimitRst  = 16'd600;
  localparam logic        [15:0] UvLimitRst  = 16'd400;
  localparam logic signed [7:0]  OtLimitRst  = 8'sd60;
  localparam logic        [14:0] OcLimitRst  = 15'd500;
  localparam logic        [7:0]  DebounceRst = 8'd3;
  localparam logic signed [7:0]  WarnTempRst = 8'sd55;

  typedef enum logic [1:0] {
    StNormal  = 2'd0,
    StWarning = 2'd1,
    StFault   = 2'd2,
    StSleep   = 2'd3
  } pack_state_e;

  typedef struct packed {
    logic        [15:0] pack_voltage;
    logic signed [15:0] pack_current;
    logic signed [7:0]  pack_temp;
    logic               link_timeout;
  } bfdm_in_t;

  typedef struct packed {
    logic [4:0]  fault_word;
    pack_state_e pack_state;
  } bfdm_out_t;

endpackage

`default_nettype wire

### rtl/battery_fault_debounce_monitor.sv
// Battery fault monitor with integrating debounce.
// Input channel: in_valid_i / in_stall_o carry one sample word (voltage,
// current, temperature, link timeout). Output channel: out_valid_o /
// out_stall_i carry one result word (five-bit fault word, pack state)
// for every sample, in order.
// An accepted sample is held in the input register and moves into the output
// register once the output is free; the receiver takes it from there.
// Throughput is one sample per cycle while the receiver does not stall: the four
// counter updates are a single compare-and-step between the input register
// and the output register.
// Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per
// cycle; write only while no sample is in flight. Unknown indexes are
// dropped; data above a register's width is discarded.
// Reset clears the valid bits of both pipeline registers, all counters and
// fault bits, and loads the default limits.
// When the receiver stalls, the result word holds; the input register
// keeps its sample and in_stall_o rises once it cannot move forward.
`default_nettype none

module battery_fault_debounce_monitor
  import bfdm_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = CounterWDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire bfdm_in_t            in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bfdm_out_t                out_word_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned CmpW = (COUNTER_WIDTH > 8) ? COUNTER_WIDTH : 8;
  localparam logic [CmpW-1:0] CntMax = CmpW'((1 << COUNTER_WIDTH) - 1);

  // configuration registers
  logic        [15:0] ov_limit_q;
  logic        [15:0] uv_limit_q;
  logic signed [7:0]  ot_limit_q;
  logic        [14:0] oc_limit_q;
  logic        [7:0]  debounce_q;
  logic signed [7:0]  warn_temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_limit_q  <= OvLimitRst;
      uv_limit_q  <= UvLimitRst;
      ot_limit_q  <= OtLimitRst;
      oc_limit_q  <= OcLimitRst;
      debounce_q  <= DebounceRst;
      warn_temp_q <= WarnTempRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOvLimit:  ov_limit_q  <= cfg_wdata_i;
        RegUvLimit:  uv_limit_q  <= cfg_wdata_i;
        RegOtLimit:  ot_limit_q  <= $signed(cfg_wdata_i[7:0]);
        RegOcLimit:  oc_limit_q  <= cfg_wdata_i[14:0];
        RegDebounce: debounce_q  <= cfg_wdata_i[7:0];
        RegWarnTemp: warn_temp_q <= $signed(cfg_wdata_i[7:0]);
        default: ;
      endcase
    end
  end

  // pipeline control
  logic     s1_valid_q;
  bfdm_in_t s1_word_q;
  logic     out_valid_q;
  logic     s1_move;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_word_q <= in_word_i;
    end
  end

  // debounce limit, clipped to what the counter can hold
  logic [CmpW-1:0]          dc_ext;
  logic [CmpW-1:0]          lim_ext;
  logic [COUNTER_WIDTH-1:0] limit;

  assign dc_ext  = CmpW'(debounce_q);
  assign lim_ext = (dc_ext > CntMax) ? CntMax : dc_ext;
  assign limit   = lim_ext[COUNTER_WIDTH-1:0];

  // channel conditions
  logic [NumChan-1:0] cond;
  logic signed [16:0] cur_ext;
  logic signed [16:0] oc_ext;

  assign cur_ext = 17'(s1_word_q.pack_current);
  assign oc_ext  = $signed({2'b00, oc_limit_q});

  always_comb begin
    cond[FaultOv] = s1_word_q.pack_voltage > ov_limit_q;
    cond[FaultUv] = s1_word_q.pack_voltage < uv_limit_q;
    cond[FaultOt] = s1_word_q.pack_temp > ot_limit_q;
    cond[FaultOc] = (cur_ext > oc_ext) || (cur_ext < -oc_ext);
  end

  // counters and fault bits
  logic [COUNTER_WIDTH-1:0] cnt_q [NumChan];
  logic [COUNTER_WIDTH-1:0] cnt_d [NumChan];
  logic [NumChan-1:0]       fault_q;
  logic [NumChan-1:0]       fault_d;

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      cnt_d[i]   = cnt_q[i];
      fault_d[i] = fault_q[i];
      if (cond[i]) begin
        if (cnt_q[i] < limit) begin
          cnt_d[i] = cnt_q[i] + 1'b1;
        end
        if (cnt_d[i] >= limit) begin
          fault_d[i] = 1'b1;
        end
      end else begin
        if (cnt_q[i] != '0) begin
          cnt_d[i] = cnt_q[i] - 1'b1;
        end
        if (cnt_d[i] == '0) begin
          fault_d[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChan; i++) begin
        cnt_q[i] <= '0;
      end
      fault_q <= '0;
    end else if (s1_move) begin
      for (int i = 0; i < NumChan; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      fault_q <= fault_d;
    end
  end

  // result word
  pack_state_e state_d;
  bfdm_out_t   out_word_q;

  always_comb begin
    if (s1_word_q.link_timeout) begin
      state_d = StSleep;
    end else if (fault_d != '0) begin
      state_d = StFault;
    end else if (s1_word_q.pack_temp > warn_temp_q) begin
      state_d = StWarning;
    end else begin
      state_d = StNormal;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_word_q.fault_word <= {s1_word_q.link_timeout, fault_d};
      out_word_q.pack_state <= state_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

### bench/testbench.sv
module testbench;
  import bfdm_pkg::*;

  localparam int CntMax = (1 << CounterWDef) - 1;
  localparam int NumRegs = 6;
  localparam int NumPhases = 9;

  // Mirror of the monitor: limits, debounce counters, fault bits and the
  // result words still owed by the block.
  class fault_tracker;
    logic        [15:0] ov_lim;
    logic        [15:0] uv_lim;
    logic signed [7:0]  ot_lim;
    logic        [14:0] oc_lim;
    logic        [7:0]  deb;
    logic signed [7:0]  warn_lim;
    int                 cnt[NumChan];
    bit [NumChan-1:0]   faults;
    bfdm_out_t          pending[$];
    int                 seen;

    function new();
      ov_lim   = OvLimitRst;
      uv_lim   = UvLimitRst;
      ot_lim   = OtLimitRst;
      oc_lim   = OcLimitRst;
      deb      = DebounceRst;
      warn_lim = WarnTempRst;
      foreach (cnt[i]) cnt[i] = 0;
      faults = '0;
      seen   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegOvLimit:  ov_lim = data;
        RegUvLimit:  uv_lim = data;
        RegOtLimit:  ot_lim = data[7:0];
        RegOcLimit:  oc_lim = data[14:0];
        RegDebounce: deb = data[7:0];
        RegWarnTemp: warn_lim = data[7:0];
        default: ;
      endcase
    endfunction

    function void count_chan(int ch, bit hold, int lim);
      if (hold) begin
        if (cnt[ch] < lim) cnt[ch]++;
        if (cnt[ch] >= lim) faults[ch] = 1'b1;
      end else begin
        if (cnt[ch] > 0) cnt[ch]--;
        if (cnt[ch] == 0) faults[ch] = 1'b0;
      end
    endfunction

    function void take_sample(bfdm_in_t s);
      int        volt;
      int        amps;
      int        temp;
      int        oc;
      int        lim;
      bfdm_out_t want;
      volt = int'(s.pack_voltage);
      amps = int'($signed(s.pack_current));
      temp = int'($signed(s.pack_temp));
      oc   = int'(oc_lim);
      lim  = (int'(deb) > CntMax) ? CntMax : int'(deb);
      count_chan(FaultOv, volt > int'(ov_lim), lim);
      count_chan(FaultUv, volt < int'(uv_lim), lim);
      count_chan(FaultOt, temp > int'(ot_lim), lim);
      count_chan(FaultOc, amps > oc || amps < -oc, lim);
      want.fault_word = {s.link_timeout, faults};
      if (s.link_timeout) want.pack_state = StSleep;
      else if (faults != '0) want.pack_state = StFault;
      else if (temp > int'(warn_lim)) want.pack_state = StWarning;
      else want.pack_state = StNormal;
      pending.push_back(want);
    endfunction

    function void check_word(bfdm_out_t got, output string notes[$]);
      bfdm_out_t want;
      notes = {};
      seen++;
      if (pending.size() == 0) begin
        notes.push_back($sformatf("result %0d arrived with no sample waiting", seen));
        return;
      end
      want = pending.pop_front();
      if (got.fault_word !== want.fault_word)
        notes.push_back($sformatf("result %0d fault_word %b, want %b", seen,
                                  got.fault_word, want.fault_word));
      if (got.pack_state !== want.pack_state)
        notes.push_back($sformatf("result %0d pack_state %0d, want %0d", seen,
                                  got.pack_state, want.pack_state));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bfdm_in_t            in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bfdm_out_t           out_word;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  fault_tracker model;
  int errors = 0;
  int gap_chance = 0;
  int stall_chance = 0;
  int stall_left = 0;
  int run_left = 0;
  int v_mode = 0;
  int c_mode = 0;
  int t_mode = 0;

  battery_fault_debounce_monitor uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #10 clk = ~clk;

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  // result side first, so a word accepted on this edge is never matched
  // against the sample taken on the same edge
  always @(posedge clk) begin
    string notes[$];
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        model.check_word(out_word, notes);
        foreach (notes[i]) report(notes[i]);
      end
      if (in_valid && !in_stall) model.take_sample(in_word);
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (stall_chance != 0 && $urandom_range(0, 99) < stall_chance) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 17);
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic int pick_chance();
    return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(5, 40));
  endfunction

  function automatic bfdm_in_t mk(int v, int c, int t, bit l);
    bfdm_in_t s;
    s.pack_voltage = v[15:0];
    s.pack_current = c[15:0];
    s.pack_temp    = t[7:0];
    s.link_timeout = l;
    return s;
  endfunction

  task automatic send_sample(input bfdm_in_t w);
    if (gap_chance != 0 && $urandom_range(0, 99) < gap_chance) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(posedge clk);
    model.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (model.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input int kind);
    int ot;
    int wt;
    case (kind)
      0: begin
        write_reg(RegOvLimit, OvLimitRst);
        write_reg(RegUvLimit, UvLimitRst);
        write_reg(RegOtLimit, 16'(OtLimitRst));
        write_reg(RegOcLimit, 16'(OcLimitRst));
        write_reg(RegDebounce, 16'(DebounceRst));
        write_reg(RegWarnTemp, 16'(WarnTempRst));
      end
      1: begin
        write_reg(RegOvLimit, 16'h0000);
        write_reg(RegUvLimit, 16'h0000);
        write_reg(RegOtLimit, 16'h0080);
        write_reg(RegOcLimit, 16'h0000);
        write_reg(RegDebounce, 16'h0001);
        write_reg(RegWarnTemp, 16'h0080);
      end
      2: begin
        write_reg(RegOvLimit, 16'hffff);
        write_reg(RegUvLimit, 16'hffff);
        write_reg(RegOtLimit, 16'h007f);
        write_reg(RegOcLimit, 16'h7fff);
        write_reg(RegDebounce, 16'h00ff);
        write_reg(RegWarnTemp, 16'h007f);
      end
      3: begin
        ot = int'($urandom_range(0, 110)) - 20;
        wt = int'($urandom_range(0, 110)) - 20;
        write_reg(RegOvLimit, 16'($urandom_range(300, 900)));
        write_reg(RegUvLimit, 16'($urandom_range(100, 700)));
        write_reg(RegOtLimit, ot[15:0]);
        write_reg(RegOcLimit, 16'($urandom_range(0, 2000)));
        write_reg(RegDebounce, 16'($urandom_range(0, 12)));
        write_reg(RegWarnTemp, wt[15:0]);
      end
      default: begin
        // whole data bus random: upper bits beyond each register get dropped
        for (int i = 0; i < NumRegs; i++) write_reg(CfgIdxW'(i), 16'($urandom));
        for (int i = NumRegs; i < (1 << CfgIdxW); i++) write_reg(CfgIdxW'(i), 16'($urandom));
      end
    endcase
  endtask

  // Conditions are held for runs so the counters actually reach the limit
  // and drain again; one word in ten is plain noise.
  task automatic pick_sample(output bfdm_in_t s);
    int ov;
    int uv;
    int oc;
    int ot;
    int wt;
    int v;
    int c;
    int t;
    ov = int'(model.ov_lim);
    uv = int'(model.uv_lim);
    oc = int'(model.oc_lim);
    ot = int'(model.ot_lim);
    wt = int'(model.warn_lim);
    if (run_left == 0) begin
      v_mode   = $urandom_range(0, 4);
      c_mode   = $urandom_range(0, 4);
      t_mode   = $urandom_range(0, 3);
      run_left = $urandom_range(1, int'(model.deb) * 2 + 4);
    end
    run_left--;
    case (v_mode)
      0: v = (ov < 65535) ? int'($urandom_range(ov + 1, 65535)) : int'($urandom_range(0, 65535));
      1: v = (uv > 0) ? int'($urandom_range(0, uv - 1)) : int'($urandom_range(0, 65535));
      2: v = (uv <= ov) ? int'($urandom_range(uv, ov)) : int'($urandom_range(0, 65535));
      3: begin
        case ($urandom_range(0, 3))
          0: v = ov;
          1: v = ov + 1;
          2: v = uv;
          default: v = uv - 1;
        endcase
      end
      default: v = $urandom_range(0, 65535);
    endcase
    case (c_mode)
      0: c = (oc < 32767) ? int'($urandom_range(oc + 1, 32767)) : 32767;
      1: c = -int'($urandom_range(oc + 1, 32768));
      2: c = int'($urandom_range(0, 2 * oc)) - oc;
      3: begin
        case ($urandom_range(0, 3))
          0: c = oc;
          1: c = oc + 1;
          2: c = -oc;
          default: c = -oc - 1;
        endcase
      end
      default: c = $urandom_range(0, 65535);
    endcase
    case (t_mode)
      0: t = (ot < 127) ? ot + 1 + int'($urandom_range(0, 126 - ot)) : 127;
      1: t = ot - int'($urandom_range(0, ot + 128));
      2: begin
        case ($urandom_range(0, 3))
          0: t = ot;
          1: t = ot + 1;
          2: t = wt;
          default: t = wt + 1;
        endcase
      end
      default: t = $urandom_range(0, 255);
    endcase
    s = mk(v, c, t, $urandom_range(0, 6) == 0);
    if ($urandom_range(0, 9) == 0)
      s = mk($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 255),
             $urandom_range(0, 1));
  endtask

  initial begin
    bfdm_in_t s;
    int       phase_kind[NumPhases] = '{0, 1, 3, 2, 4, 3, 4, 3, 0};
    int       phase_len[NumPhases]  = '{150, 150, 150, 450, 150, 150, 150, 150, 300};
    model = new();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset limits: extremes of every field and both directions of current
    gap_chance   = 20;
    stall_chance = 30;
    repeat (3) send_sample(mk(0, -32768, -128, 0));
    send_sample(mk(65535, 32767, 127, 0));
    send_sample(mk(600, 500, 60, 1));
    send_sample(mk(601, 501, 61, 0));
    send_sample(mk(399, -501, 56, 0));
    send_sample(mk(400, -500, 55, 0));
    repeat (4) send_sample(mk(500, 0, 56, 0));
    send_sample(mk(500, 0, 0, 0));
    wait_drained();

    // debounce of zero via a wide write, plus writes to unused indexes
    write_reg(RegDebounce, 16'hff00);
    for (int i = NumRegs; i < (1 << CfgIdxW); i++) write_reg(CfgIdxW'(i), 16'($urandom));
    send_sample(mk(65535, 0, 0, 0));
    send_sample(mk(500, 0, 0, 0));
    send_sample(mk(0, 1000, 100, 1));
    send_sample(mk(500, 0, 0, 0));
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      set_config(phase_kind[p]);
      run_left = 0;
      if (p == NumPhases - 1) begin
        gap_chance   = 0;
        stall_chance = 0;
      end else begin
        gap_chance   = pick_chance();
        stall_chance = pick_chance();
      end
      for (int n = 0; n < phase_len[p]; n++) begin
        pick_sample(s);
        send_sample(s);
      end
      in_valid = 1'b0;
      if (p != NumPhases - 1) wait_drained();
    end

    in_valid = 1'b0;
    for (int n = 0; n < 2000 && model.pending.size() != 0; n++) @(negedge clk);
    repeat (10) @(negedge clk);
    if (model.pending.size() != 0)
      report($sformatf("%0d result words never arrived", model.pending.size()));
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
